>>> sv/rc5x_pkg.sv
package rc5x_pkg;

    // field widths
    localparam int SYS_W  = 5;
    localparam int CMD_W  = 7;
    localparam int DATA_W = 6;

    // frame register holds the extended frame, the standard one is left aligned
    localparam int FRAME_W = 22;
    localparam int POS_W   = $clog2(FRAME_W);

    // position of the first bit sent
    localparam logic [POS_W-1:0] STD_TOP = POS_W'(13);
    localparam logic [POS_W-1:0] EXT_TOP = POS_W'(21);

    // extended frame: bit positions that are held low as the pause
    localparam logic [POS_W-1:0] PAUSE_HI = POS_W'(13);
    localparam logic [POS_W-1:0] PAUSE_LO = POS_W'(12);

    // stream word widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // one half-bit slot
    typedef struct packed {
        logic level;
        logic last;
    } slot_t;

endpackage

>>> sv/rc5x_serializer.sv
module rc5x_serializer
    import rc5x_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              extended,
    input  logic [SYS_W-1:0]  system_addr,
    input  logic [CMD_W-1:0]  command_code,
    input  logic [DATA_W-1:0] data_ext,
    input  logic              slot_take,
    output logic              busy,
    output logic              slot_valid,
    output slot_t             slot
);

    logic               busy_reg, busy_next;
    logic               phase_reg, phase_next;
    logic               ext_reg, ext_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               cur_bit;
    logic               in_pause;

    assign cur_bit  = frame_reg[FRAME_W-1];
    assign in_pause = ext_reg && (pos_reg == PAUSE_HI || pos_reg == PAUSE_LO);

    // one is sent low then high
    assign slot.level = in_pause ? 1'b0 : (phase_reg ? cur_bit : ~cur_bit);
    assign slot.last  = (pos_reg == '0) && phase_reg;
    assign slot_valid = busy_reg;
    assign busy       = busy_reg;

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        ext_next   = ext_reg;
        pos_next   = pos_reg;
        frame_next = frame_reg;
        if (load) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            ext_next   = extended;
            if (extended) begin
                pos_next   = EXT_TOP;
                frame_next = {1'b1, ~command_code[CMD_W-1], 1'b0, system_addr, 2'b00,
                              command_code[CMD_W-2:0], data_ext};
            end else begin
                pos_next   = STD_TOP;
                frame_next = {1'b1, ~command_code[CMD_W-1], 1'b0, system_addr,
                              command_code[CMD_W-2:0], 8'b0};
            end
        end else if (busy_reg && slot_take) begin
            phase_next = ~phase_reg;
            if (phase_reg) begin
                // second half done, move to the next bit
                frame_next = {frame_reg[FRAME_W-2:0], 1'b0};
                pos_next   = pos_reg - POS_W'(1);
                if (pos_reg == '0) begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        phase_reg <= phase_next;
        ext_reg   <= ext_next;
        pos_reg   <= pos_next;
        frame_reg <= frame_next;
    end

endmodule

>>> sv/rc5_rc5x_frame_encoder.sv
// rc5 / rc5x infrared frame encoder. each accepted input word is one remote
// command; the block sends the frame as manchester half-bit slot levels, one
// output word per slot, with tlast on the final slot. a one bit goes out low
// then high, a zero bit high then low. standard frames (tuser low) give 28
// slots: start, inverted command bit 6, toggle (always 0), system[4:0],
// command[5:0]. extended frames (tuser high) give 44 slots: the same head,
// four low pause slots, then command[5:0] and data[5:0]. a frame register is
// shifted one bit per two slots, so the encoder emits one slot per cycle
// unless the output side stalls it. the next command is accepted as soon as
// the final slot has moved into the output register, while that slot still
// waits to be taken. no slot timing, carrier or pin handling is done here.
module rc5_rc5x_frame_encoder
    import rc5x_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // command input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // system_addr[4:0], command_code[11:5],
                                            // data_ext[17:12], zeros above
    input  logic                 s_tuser,   // extended
    // slot output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // line_level[0], zeros above
    output logic                 m_tlast    // last_slot
);

    logic  load;
    logic  busy;
    logic  slot_valid;
    logic  slot_take;
    slot_t slot;

    // output register
    logic m_valid_reg, m_valid_next;
    logic level_reg, level_next;
    logic last_reg, last_next;

    // a new command loads only when the serializer is done
    assign s_tready = !busy;
    assign load     = s_tvalid && s_tready;

    // a slot moves into the output register when it is empty or being drained
    assign slot_take = slot_valid && (!m_valid_reg || m_tready);

    rc5x_serializer u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .extended     (s_tuser),
        .system_addr  (s_tdata[SYS_W-1:0]),
        .command_code (s_tdata[SYS_W+CMD_W-1:SYS_W]),
        .data_ext     (s_tdata[SYS_W+CMD_W+DATA_W-1:SYS_W+CMD_W]),
        .slot_take    (slot_take),
        .busy         (busy),
        .slot_valid   (slot_valid),
        .slot         (slot)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        level_next   = level_reg;
        last_next    = last_reg;
        if (slot_take) begin
            m_valid_next = 1'b1;
            level_next   = slot.level;
            last_next    = slot.last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        level_reg <= level_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, level_reg};
    assign m_tlast  = last_reg;

endmodule
